[src/srest_pkg.sv]
package srest_pkg;

  // field widths
  localparam int unsigned DataW  = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned StatW  = 2;

  // divider sizing: ds * 1e6 + dt/2 fits in 52 bits
  localparam int unsigned DivW     = 52;
  localparam int unsigned DivSteps = DivW;
  localparam int unsigned DivCntW  = 6;

  // default configuration
  localparam logic [DataW-1:0] DefNominal = 32'd500000;
  localparam logic [DataW-1:0] DefMinRate = 32'd450000;
  localparam logic [DataW-1:0] DefMaxRate = 32'd550000;
  localparam logic [DataW-1:0] DefMinObs  = 32'd5000;
  localparam logic [19:0]      MicroPerUnit = 20'd1000000;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegNominal = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMinRate = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxRate = 2'd2;
  localparam logic [CfgIdxW-1:0] RegMinObs  = 2'd3;

  // result status codes
  typedef logic [StatW-1:0] status_t;
  localparam status_t StatAnchored = 2'd0;
  localparam status_t StatWait     = 2'd1;
  localparam status_t StatRange    = 2'd2;
  localparam status_t StatUpdated  = 2'd3;

  // sequencer
  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMul  = 5'b00010,
    StLoad = 5'b00100,
    StDiv  = 5'b01000,
    StDone = 5'b10000
  } state_e;

  // divider handshake
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
  } div_stat_t;

endpackage

[src/srest_div.sv]
module srest_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  srest_pkg::div_ctrl_t              ctrl_i,
  input  logic [srest_pkg::DivW-1:0]        dividend_i,
  input  logic [srest_pkg::DataW-1:0]       divisor_i,
  output srest_pkg::div_stat_t              stat_o,
  output logic [srest_pkg::DivW-1:0]        quot_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [srest_pkg::DivCntW-1:0]     cnt_q, cnt_d;
  logic [srest_pkg::DataW-1:0]       rem_q, rem_d;
  logic [srest_pkg::DivW-1:0]        quo_q, quo_d;
  logic [srest_pkg::DataW-1:0]       dvs_q, dvs_d;
  logic [srest_pkg::DataW:0]         rem_sh;
  logic [srest_pkg::DataW:0]         diff;
  logic                              fits;

  // one restoring step per cycle, quotient bits shift in behind the dividend
  assign rem_sh = {rem_q, quo_q[srest_pkg::DivW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign fits   = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[srest_pkg::DataW-1:0] : rem_sh[srest_pkg::DataW-1:0];
      quo_d = {quo_q[srest_pkg::DivW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == srest_pkg::DivCntW'(srest_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

[src/sample_rate_estimator_core.sv]
// sample rate estimator
//
// input stream: one word per observation, sample counter and millisecond
// clock. the first word after reset becomes the anchor; each later word
// measures the wrapped sample and time distance from that anchor and, once
// enough time has passed, forms round(ds * 1e6 / dt) in millihertz. a rate
// inside [min_rate, max_rate] replaces the estimate.
// output stream: exactly one result word per input word, carrying a status
// code, an update flag, the current rate and an estimate-valid flag.
// config port: cfg_we_i writes one of four 32-bit registers; an invalid set
// makes the block use the default set as a whole.
// sequencing: anchor, too-early and zero-distance words go from accept
// straight to the done state; a word that needs a division first passes
// the multiply and load states and the 52-step restoring divider (one
// quotient bit per cycle). input ready drops until the result moves to the
// output register, so no new word is taken while one is in flight.
// reset clears the anchor and the valid flag and loads the default config.
// a stalled output holds its word; the next input word may still be taken
// and worked on, and its result waits in the sequencer until the slot frees.
module sample_rate_estimator_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write port
  input  logic                               cfg_we_i,
  input  logic [srest_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [srest_pkg::DataW-1:0]        cfg_wdata_i,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [63:0]                        s_axis_tdata,  // sample_count, time_ms
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [39:0]                        m_axis_tdata   // status, updated, rate_out,
                                                            // valid_out, zero pad
);

  // config registers
  logic [srest_pkg::DataW-1:0] nom_reg_q, lo_reg_q, hi_reg_q, obs_reg_q;

  // effective config, checked as a set
  logic                        cfg_bad;
  logic [srest_pkg::DataW-1:0] eff_nom, eff_lo, eff_hi, eff_obs;

  // sequencer and item state
  srest_pkg::state_e           state_q, state_d;
  logic                        anchored_q;
  logic                        est_ok_q;
  logic [srest_pkg::DataW-1:0] est_q;
  logic [srest_pkg::DataW-1:0] anc_cnt_q, anc_time_q;
  logic [srest_pkg::DataW-1:0] ds_q, dt_q;
  logic [srest_pkg::DataW-1:0] nom_q, lo_q, hi_q;
  logic [srest_pkg::DivW-1:0]  prod_q;
  srest_pkg::status_t          status_q;

  // output register
  logic                        out_valid_q;
  srest_pkg::status_t          out_status_q;
  logic                        out_upd_q;
  logic [srest_pkg::DataW-1:0] out_rate_q;
  logic                        out_vld_q;

  // datapath
  logic [srest_pkg::DataW-1:0] in_cnt, in_time, ds, dt;
  logic                        accept, emit, rate_ok;
  logic [srest_pkg::DivW-1:0]  dividend;
  logic [srest_pkg::DivW-1:0]  quot;
  srest_pkg::div_ctrl_t        div_ctrl;
  srest_pkg::div_stat_t        div_stat;

  assign in_cnt  = s_axis_tdata[31:0];
  assign in_time = s_axis_tdata[63:32];
  assign ds      = in_cnt - anc_cnt_q;
  assign dt      = in_time - anc_time_q;

  assign cfg_bad = (nom_reg_q == '0) || (lo_reg_q == '0) ||
                   (hi_reg_q <= lo_reg_q) || (obs_reg_q == '0);
  assign eff_nom = cfg_bad ? srest_pkg::DefNominal : nom_reg_q;
  assign eff_lo  = cfg_bad ? srest_pkg::DefMinRate : lo_reg_q;
  assign eff_hi  = cfg_bad ? srest_pkg::DefMaxRate : hi_reg_q;
  assign eff_obs = cfg_bad ? srest_pkg::DefMinObs  : obs_reg_q;

  assign s_axis_tready = (state_q == srest_pkg::StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  // result leaves the sequencer once the output slot is free or draining
  assign emit          = (state_q == srest_pkg::StDone) && (!out_valid_q || m_axis_tready);

  // rounding term added on the way into the divider
  assign dividend    = prod_q + srest_pkg::DivW'(dt_q[srest_pkg::DataW-1:1]);
  assign div_ctrl.start = (state_q == srest_pkg::StLoad);

  // quotient wider than 32 bits is out of range, never truncated
  assign rate_ok = (quot[srest_pkg::DivW-1:srest_pkg::DataW] == '0) &&
                   (quot[srest_pkg::DataW-1:0] >= lo_q) &&
                   (quot[srest_pkg::DataW-1:0] <= hi_q);

  srest_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (dividend),
    .divisor_i  (dt_q),
    .stat_o     (div_stat),
    .quot_o     (quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      srest_pkg::StIdle: begin
        if (accept) begin
          if (!anchored_q || ds == '0 || dt < eff_obs) begin
            state_d = srest_pkg::StDone;
          end else begin
            state_d = srest_pkg::StMul;
          end
        end
      end
      srest_pkg::StMul:  state_d = srest_pkg::StLoad;
      srest_pkg::StLoad: state_d = srest_pkg::StDiv;
      srest_pkg::StDiv: begin
        if (div_stat.done) begin
          state_d = srest_pkg::StDone;
        end
      end
      srest_pkg::StDone: begin
        if (emit) begin
          state_d = srest_pkg::StIdle;
        end
      end
      default: state_d = srest_pkg::StIdle;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srest_pkg::StIdle;
      anchored_q  <= 1'b0;
      est_ok_q    <= 1'b0;
      anc_cnt_q   <= '0;
      anc_time_q  <= '0;
      out_valid_q <= 1'b0;
      nom_reg_q   <= srest_pkg::DefNominal;
      lo_reg_q    <= srest_pkg::DefMinRate;
      hi_reg_q    <= srest_pkg::DefMaxRate;
      obs_reg_q   <= srest_pkg::DefMinObs;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          srest_pkg::RegNominal: nom_reg_q <= cfg_wdata_i;
          srest_pkg::RegMinRate: lo_reg_q  <= cfg_wdata_i;
          srest_pkg::RegMaxRate: hi_reg_q  <= cfg_wdata_i;
          srest_pkg::RegMinObs:  obs_reg_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (accept && !anchored_q) begin
        anchored_q <= 1'b1;
        anc_cnt_q  <= in_cnt;
        anc_time_q <= in_time;
      end
      if (state_q == srest_pkg::StDiv && div_stat.done && rate_ok) begin
        est_ok_q <= 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ds_q  <= ds;
      dt_q  <= dt;
      nom_q <= eff_nom;
      lo_q  <= eff_lo;
      hi_q  <= eff_hi;
      if (!anchored_q) begin
        status_q <= srest_pkg::StatAnchored;
      end else begin
        status_q <= srest_pkg::StatWait;
      end
    end
    if (state_q == srest_pkg::StMul) begin
      prod_q <= srest_pkg::DivW'(ds_q) * srest_pkg::DivW'(srest_pkg::MicroPerUnit);
    end
    if (state_q == srest_pkg::StDiv && div_stat.done) begin
      if (rate_ok) begin
        est_q    <= quot[srest_pkg::DataW-1:0];
        status_q <= srest_pkg::StatUpdated;
      end else begin
        status_q <= srest_pkg::StatRange;
      end
    end
    if (emit) begin
      out_status_q <= status_q;
      out_upd_q    <= (status_q == srest_pkg::StatUpdated);
      out_rate_q   <= est_ok_q ? est_q : nom_q;
      out_vld_q    <= est_ok_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_vld_q, out_rate_q, out_upd_q, out_status_q};

endmodule
